// File: rtl/wng_pkg.sv
// Shared package of the wind noise generator: field widths, register indexes,
// reset values, microcode control word and the fixed-point helper functions.
// Depends on nothing; every other file of the block imports it.
package wng_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 16;
   localparam int WORD_W   = 32;
   localparam int SINE_W   = 17;
   localparam int MUL_A_W  = 25;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W    = PROD_W + 1;

   localparam int SINE_TABLE_DEPTH = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEED       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAK       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LFO_INC    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUST_BASE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUST_DEPTH = 3'd6;

   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_NOISE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_BROWN = 3'd2;
   localparam logic [STEP_W-1:0] STEP_LP1   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LP2   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_GAIN  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_OUT   = 3'd6;

   typedef struct packed {
      logic [WORD_W-1:0] seed;
      logic [COEF_W-1:0] noise_gain;
      logic [COEF_W-1:0] leak;
      logic [COEF_W-1:0] smoothing_coef;
      logic [WORD_W-1:0] lfo_increment;
      logic [COEF_W-1:0] gust_base;
      logic [COEF_W-1:0] gust_depth;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      seed:           32'd388821,
      noise_gain:     16'd2294,
      leak:           16'd65339,
      smoothing_coef: 16'd7864,
      lfo_increment:  32'd24348,
      gust_base:      16'd36045,
      gust_depth:     16'd29491
   };

   typedef enum logic [2:0] {
      SRC_NOISE, SRC_ACC, SRC_DIFF1, SRC_DIFF2, SRC_SINE, SRC_LP2
   } src_a_type;

   typedef enum logic [2:0] {
      COEF_NGAIN, COEF_LEAK, COEF_SMOOTH, COEF_DEPTH, COEF_GAIN
   } src_b_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_ACC, DST_BROWN, DST_LP1, DST_LP2, DST_GAIN, DST_OUT
   } dst_type;

   typedef enum logic [1:0] {
      JMP_NEVER, JMP_ALWAYS, JMP_NO_REQ, JMP_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic              start;
      src_a_type         src_a;
      src_b_type         src_b;
      dst_type           dst;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic out_busy;
   } seq_status_type;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      logic signed [SAMPLE_W-1:0] res;
      if (v > SUM_W'(8388607)) begin
         res = 24'sd8388607;
      end else if (v < -SUM_W'(8388608)) begin
         res = -24'sd8388608;
      end else begin
         res = v[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [COEF_W-1:0] clamp16(input logic signed [SUM_W-1:0] v);
      logic [COEF_W-1:0] res;
      if (v < SUM_W'(0)) begin
         res = '0;
      end else if (v > SUM_W'(65535)) begin
         res = '1;
      end else begin
         res = v[COEF_W-1:0];
      end
      return res;
   endfunction

   // Quarter-wave polynomial sine of an angle in 1/65536 turn units, Q1.15.
   function automatic logic signed [SINE_W-1:0] sine_value(input longint ang);
      longint quad;
      longint r;
      longint z;
      longint z2;
      longint t;
      quad = (ang >> 14) & 3;
      r    = ang & 16383;
      if (quad == 1 || quad == 3) begin
         r = 16384 - r;
      end
      z  = r * 2;
      z2 = (z * z) >> 15;
      t  = (2320 * z2) >> 15;
      t  = 21024 - t;
      t  = (z2 * t) >> 15;
      t  = 51472 - t;
      t  = (z * t) >> 15;
      if (quad >= 2) begin
         t = -t;
      end
      return t[SINE_W-1:0];
   endfunction

endpackage

// File: rtl/wng_sine_rom.sv
// Read-only sine table of the gust modulator, one registered read per access.
// Entries are built at elaboration from wng_pkg::sine_value.
module wng_sine_rom #(
   parameter int DEPTH = wng_pkg::SINE_TABLE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   rd_en,
   input  logic [$clog2(DEPTH)-1:0]               rd_index,
   output logic signed [wng_pkg::SINE_W-1:0]      rd_data
);
   import wng_pkg::*;

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int ANG_SHIFT = 16 - IDX_W;

   logic signed [SINE_W-1:0] rom [DEPTH];
   logic signed [SINE_W-1:0] data_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      localparam logic signed [SINE_W-1:0] VALUE = sine_value(longint'(g) << ANG_SHIFT);
      assign rom[g] = VALUE;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom[rd_index];
      end
   end

   assign rd_data = data_ff;

endmodule

// File: rtl/wng_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on wng_pkg for the control word and status types.
module wng_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  wng_pkg::seq_status_type status,
   output wng_pkg::ctl_type        ctl
);
   import wng_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctl_type           word;
   logic              taken;

   always_comb begin
      word = '{start: 1'b0, src_a: SRC_NOISE, src_b: COEF_NGAIN, dst: DST_NONE,
               cond: JMP_NEVER, target: STEP_WAIT, last: 1'b0};
      unique case (step_ff)
         STEP_WAIT: begin
            word.start  = 1'b1;
            word.cond   = JMP_NO_REQ;
            word.target = STEP_WAIT;
         end
         STEP_NOISE: begin
            word.src_a = SRC_NOISE;
            word.src_b = COEF_NGAIN;
            word.dst   = DST_ACC;
         end
         STEP_BROWN: begin
            word.src_a = SRC_ACC;
            word.src_b = COEF_LEAK;
            word.dst   = DST_BROWN;
         end
         STEP_LP1: begin
            word.src_a = SRC_DIFF1;
            word.src_b = COEF_SMOOTH;
            word.dst   = DST_LP1;
         end
         STEP_LP2: begin
            word.src_a = SRC_DIFF2;
            word.src_b = COEF_SMOOTH;
            word.dst   = DST_LP2;
         end
         STEP_GAIN: begin
            word.src_a = SRC_SINE;
            word.src_b = COEF_DEPTH;
            word.dst   = DST_GAIN;
         end
         STEP_OUT: begin
            word.src_a  = SRC_LP2;
            word.src_b  = COEF_GAIN;
            word.dst    = DST_OUT;
            word.cond   = JMP_OUT_BUSY;
            word.target = STEP_OUT;
            word.last   = 1'b1;
         end
         default: begin
            word.cond   = JMP_ALWAYS;
            word.target = STEP_WAIT;
         end
      endcase
   end

   always_comb begin
      unique case (word.cond)
         JMP_ALWAYS:   taken = 1'b1;
         JMP_NO_REQ:   taken = !status.req_valid;
         JMP_OUT_BUSY: taken = status.out_busy;
         default:      taken = 1'b0;
      endcase
      if (taken) begin
         step_in = word.target;
      end else if (word.last) begin
         step_in = STEP_WAIT;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl = word;

   assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_OUT && status.out_busy |=> step_ff == STEP_OUT)
      else $error("sequencer left the output step while the output was busy");

   assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_WAIT && status.req_valid |=> step_ff == STEP_NOISE)
      else $error("accepted word did not start the program");

   assert property (@(posedge clock) disable iff (reset)
      step_ff != STEP_WAIT && step_ff != STEP_OUT |=> step_ff == $past(step_ff) + STEP_W'(1))
      else $error("arithmetic step did not advance");

endmodule

// File: rtl/wng_datapath.sv
// Datapath of the wind noise generator: noise generator, filter and phase
// registers, one shared multiplier, the sine table and the output register.
// Depends on wng_pkg and wng_sine_rom.
module wng_datapath #(
   parameter int SINE_TABLE_DEPTH = wng_pkg::SINE_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wng_pkg::ctl_type                      ctl,
   input  wng_pkg::cfg_type                      cfg,
   input  logic                                  req_valid,
   input  logic                                  req_restart,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [wng_pkg::SAMPLE_W-1:0]   rsp_wind_sample,
   output logic [wng_pkg::COEF_W-1:0]            rsp_gust_gain,
   output wng_pkg::seq_status_type               status
);
   import wng_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

   logic [WORD_W-1:0]          noise_ff, noise_in;
   logic signed [SAMPLE_W-1:0] brown_ff, brown_in;
   logic signed [SAMPLE_W-1:0] lp1_ff, lp1_in;
   logic signed [SAMPLE_W-1:0] lp2_ff, lp2_in;
   logic [WORD_W-1:0]          phase_ff, phase_in;
   logic signed [MUL_A_W-1:0]  acc_ff, acc_in;
   logic [COEF_W-1:0]          gain_ff, gain_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_wind_ff;
   logic [COEF_W-1:0]          out_gain_ff;

   logic                       fire;
   logic                       out_busy;
   logic                       out_load;
   logic [WORD_W-1:0]          seed_src;
   logic [IDX_W-1:0]           sine_index;
   logic signed [SINE_W-1:0]   sine;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   shifted;
   logic signed [PROD_W-1:0]   addend;
   logic signed [SUM_W-1:0]    sum;

   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] v;
      v = s ^ (s << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   assign fire     = ctl.start && req_valid;
   assign out_busy = out_valid_ff && rsp_stall;
   assign out_load = (ctl.dst == DST_OUT) && !out_busy;

   assign seed_src   = req_restart ? cfg.seed : noise_ff;
   assign sine_index = req_restart ? '0 : phase_ff[WORD_W-1 -: IDX_W];

   wng_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock    (clock),
      .rd_en    (fire),
      .rd_index (sine_index),
      .rd_data  (sine)
   );

   always_comb begin
      case (ctl.src_a)
         SRC_NOISE: mul_a = MUL_A_W'($signed({~noise_ff[SAMPLE_W-1], noise_ff[SAMPLE_W-2:0]}));
         SRC_ACC:   mul_a = acc_ff;
         SRC_DIFF1: mul_a = MUL_A_W'(brown_ff) - MUL_A_W'(lp1_ff);
         SRC_DIFF2: mul_a = MUL_A_W'(lp1_ff) - MUL_A_W'(lp2_ff);
         SRC_SINE:  mul_a = MUL_A_W'(sine);
         SRC_LP2:   mul_a = MUL_A_W'(lp2_ff);
         default:   mul_a = '0;
      endcase
      case (ctl.src_b)
         COEF_NGAIN:  mul_b = $signed({1'b0, cfg.noise_gain});
         COEF_LEAK:   mul_b = $signed({1'b0, cfg.leak});
         COEF_SMOOTH: mul_b = $signed({1'b0, cfg.smoothing_coef});
         COEF_DEPTH:  mul_b = $signed({1'b0, cfg.gust_depth});
         COEF_GAIN:   mul_b = $signed({1'b0, gain_ff});
         default:     mul_b = '0;
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      case (ctl.dst)
         DST_ACC: begin
            shifted = prod >>> 19;
            addend  = PROD_W'(brown_ff);
         end
         DST_LP1: begin
            shifted = prod >>> 16;
            addend  = PROD_W'(lp1_ff);
         end
         DST_LP2: begin
            shifted = prod >>> 16;
            addend  = PROD_W'(lp2_ff);
         end
         DST_GAIN: begin
            shifted = prod >>> 15;
            addend  = $signed(PROD_W'(cfg.gust_base));
         end
         default: begin
            shifted = prod >>> 16;
            addend  = '0;
         end
      endcase
      sum = SUM_W'(shifted) + SUM_W'(addend);
   end

   always_comb begin
      noise_in     = noise_ff;
      brown_in     = brown_ff;
      lp1_in       = lp1_ff;
      lp2_in       = lp2_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      gain_in      = gain_ff;
      out_valid_in = out_busy;
      if (fire) begin
         noise_in = xorshift(seed_src);
         if (req_restart) begin
            brown_in = '0;
            lp1_in   = '0;
            lp2_in   = '0;
            phase_in = '0;
         end
      end
      case (ctl.dst)
         DST_ACC:   acc_in   = sum[MUL_A_W-1:0];
         DST_BROWN: brown_in = sat24(sum);
         DST_LP1:   lp1_in   = sat24(sum);
         DST_LP2:   lp2_in   = sat24(sum);
         DST_GAIN: begin
            gain_in  = clamp16(sum);
            phase_in = phase_ff + cfg.lfo_increment;
         end
         default: ;
      endcase
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff     <= CFG_RESET.seed;
         brown_ff     <= '0;
         lp1_ff       <= '0;
         lp2_ff       <= '0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         noise_ff     <= noise_in;
         brown_ff     <= brown_in;
         lp1_ff       <= lp1_in;
         lp2_ff       <= lp2_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      gain_ff <= gain_in;
      if (out_load) begin
         out_wind_ff <= sat24(sum);
         out_gain_ff <= gain_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_wind_sample  = out_wind_ff;
   assign rsp_gust_gain    = out_gain_ff;
   assign status.req_valid = req_valid;
   assign status.out_busy  = out_busy;

   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(ctl.dst == DST_OUT))
      else $error("output word appeared without an output step");

   assert property (@(posedge clock) disable iff (reset)
      fire && req_restart |=> phase_ff == '0 && brown_ff == '0)
      else $error("restart did not clear the signal state");

   assert property (@(posedge clock) disable iff (reset)
      ctl.dst == DST_GAIN |=> phase_ff == $past(phase_ff) + $past(cfg.lfo_increment))
      else $error("gust phase did not advance on the gain step");

endmodule

// File: rtl/wind_noise_generator.sv
// Top level of the wind noise generator: configuration registers, the
// microcode sequencer and the datapath. Depends on wng_pkg, wng_sequencer
// and wng_datapath.
//
// Usage: each word on the req_ channel is one sample tick; req_restart set
// reloads the seed and clears the filters and the gust phase before that
// tick. The rsp_ channel returns one word per tick: the saturated Q3.20
// wind sample and the Q0.16 gust gain applied to it.
// A word accepted in the wait step passes the noise, brown, lp1, lp2 and
// gain steps, and the output step loads it into the output register that
// drives rsp_valid. The single shared multiplier serves the six products of
// the tick in turn; the next word is taken only after the output step.
// The csr_ port writes one register per cycle when csr_wr_en is high;
// writes to unused indexes are dropped. Write only while the block is idle.
// Reset loads the default register values, seeds the noise generator and
// clears all filter state and the phase. When the receiver stalls, the
// finished word waits in the output register; the next tick is accepted and
// computed meanwhile, and the sequencer holds at its last step until the
// output register is free.
module wind_noise_generator #(
   parameter int SINE_TABLE_DEPTH = wng_pkg::SINE_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [wng_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wng_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wng_pkg::SAMPLE_W-1:0]   rsp_wind_sample,
   output logic [wng_pkg::COEF_W-1:0]            rsp_gust_gain
);
   import wng_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   ctl_type        ctl;
   seq_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEED:       cfg_in.seed           = csr_wdata;
            CSR_NOISE_GAIN: cfg_in.noise_gain     = csr_wdata[COEF_W-1:0];
            CSR_LEAK:       cfg_in.leak           = csr_wdata[COEF_W-1:0];
            CSR_SMOOTHING:  cfg_in.smoothing_coef = csr_wdata[COEF_W-1:0];
            CSR_LFO_INC:    cfg_in.lfo_increment  = csr_wdata;
            CSR_GUST_BASE:  cfg_in.gust_base      = csr_wdata[COEF_W-1:0];
            CSR_GUST_DEPTH: cfg_in.gust_depth     = csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wng_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   wng_datapath #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_restart     (req_restart),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_wind_sample (rsp_wind_sample),
      .rsp_gust_gain   (rsp_gust_gain),
      .status          (status)
   );

   assign req_stall = !ctl.start;

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while a tick was in progress");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##5 ctl.dst == DST_OUT)
      else $error("tick did not reach the output step on time");

   assert property (@(posedge clock) disable iff (reset)
      ctl.dst == DST_OUT |-> req_stall)
      else $error("input open during the output step");

endmodule

// File: test/wng_checker.sv
// Checker of the wind noise generator: follows the csr_, req_ and rsp_ ports,
// predicts each output word from its own copy of the registers and filter
// state, and counts mismatches. Depends on wng_pkg for widths and indexes.
module wng_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wng_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wng_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_restart,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [wng_pkg::SAMPLE_W-1:0] rsp_wind_sample,
   input  logic [wng_pkg::COEF_W-1:0]          rsp_gust_gain,
   output int                                  fail_count,
   output int                                  words_waiting
);
   import wng_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [COEF_W-1:0]          gain;
   } wind_word_type;

   cfg_type                    regs;
   logic [WORD_W-1:0]          noise_state;
   logic signed [SAMPLE_W-1:0] brown_level;
   logic signed [SAMPLE_W-1:0] lowpass_one;
   logic signed [SAMPLE_W-1:0] lowpass_two;
   logic [WORD_W-1:0]          gust_phase;
   wind_word_type              wind_words_due[$];

   function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
      if (v > 8388607) begin
         return 24'sd8388607;
      end else if (v < -8388608) begin
         return -24'sd8388608;
      end
      return SAMPLE_W'(v);
   endfunction

   // Quarter-wave polynomial sine of a table entry, Q1.15.
   function automatic longint sine_q15(input longint idx);
      longint angle;
      longint fold;
      longint z;
      longint zsq;
      longint poly;
      angle = (idx * 65536) / SINE_TABLE_DEPTH;
      fold  = angle & 16383;
      if (angle[14]) begin
         fold = 16384 - fold;
      end
      z    = 2 * fold;
      zsq  = (z * z) >>> 15;
      poly = 21024 - ((2320 * zsq) >>> 15);
      poly = 51472 - ((zsq * poly) >>> 15);
      poly = (z * poly) >>> 15;
      return angle[15] ? -poly : poly;
   endfunction

   function automatic wind_word_type next_wind_word(input logic restart);
      wind_word_type     word;
      logic [WORD_W-1:0] s;
      longint            n;
      longint            acc;
      longint            idx;
      longint            g;
      if (restart) begin
         noise_state = regs.seed;
         brown_level = '0;
         lowpass_one = '0;
         lowpass_two = '0;
         gust_phase  = '0;
      end
      s = noise_state;
      s ^= s << 13;
      s ^= s >> 17;
      s ^= s << 5;
      noise_state = s;
      n = longint'(s[23:0]) - 8388608;

      acc         = longint'(brown_level) + ((n * longint'(regs.noise_gain)) >>> 19);
      brown_level = clip_sample((acc * longint'(regs.leak)) >>> 16);
      acc         = longint'(brown_level) - longint'(lowpass_one);
      lowpass_one = clip_sample(longint'(lowpass_one)
                                + ((acc * longint'(regs.smoothing_coef)) >>> 16));
      acc         = longint'(lowpass_one) - longint'(lowpass_two);
      lowpass_two = clip_sample(longint'(lowpass_two)
                                + ((acc * longint'(regs.smoothing_coef)) >>> 16));

      idx = (longint'(gust_phase) * SINE_TABLE_DEPTH) >>> 32;
      g   = longint'(regs.gust_base)
            + ((longint'(regs.gust_depth) * sine_q15(idx)) >>> 15);
      if (g < 0) begin
         g = 0;
      end else if (g > 65535) begin
         g = 65535;
      end
      gust_phase = gust_phase + regs.lfo_increment;

      word.gain   = COEF_W'(g);
      word.sample = clip_sample((longint'(lowpass_two) * g) >>> 16);
      return word;
   endfunction

   always @(posedge clock) begin
      wind_word_type due;
      if (reset) begin
         regs        = CFG_RESET;
         noise_state = CFG_RESET.seed;
         brown_level = '0;
         lowpass_one = '0;
         lowpass_two = '0;
         gust_phase  = '0;
         fail_count  = 0;
         wind_words_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SEED: begin
                  regs.seed = csr_wdata;
               end
               CSR_NOISE_GAIN: begin
                  regs.noise_gain = csr_wdata[COEF_W-1:0];
               end
               CSR_LEAK: begin
                  regs.leak = csr_wdata[COEF_W-1:0];
               end
               CSR_SMOOTHING: begin
                  regs.smoothing_coef = csr_wdata[COEF_W-1:0];
               end
               CSR_LFO_INC: begin
                  regs.lfo_increment = csr_wdata;
               end
               CSR_GUST_BASE: begin
                  regs.gust_base = csr_wdata[COEF_W-1:0];
               end
               CSR_GUST_DEPTH: begin
                  regs.gust_depth = csr_wdata[COEF_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (wind_words_due.size() == 0) begin
               $display("%0t: output word with none due: sample %0d, gain %0d",
                        $time, rsp_wind_sample, rsp_gust_gain);
               fail_count++;
            end else begin
               due = wind_words_due.pop_front();
               if (rsp_wind_sample !== due.sample) begin
                  $display("%0t: wind_sample expected %0d, actual %0d",
                           $time, due.sample, rsp_wind_sample);
                  fail_count++;
               end
               if (rsp_gust_gain !== due.gain) begin
                  $display("%0t: gust_gain expected %0d, actual %0d",
                           $time, due.gain, rsp_gust_gain);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            wind_words_due.push_back(next_wind_word(req_restart));
         end
      end
      words_waiting = wind_words_due.size();
   end

endmodule

// File: test/tb_top.sv
// Top of the wind noise generator testbench: clock, reset, register writes,
// sample ticks with random gaps and output stalls, and the verdict.
// Depends on wng_pkg, wind_noise_generator and wng_checker.
module tb_top;
   import wng_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_TICKS = 1900;
   localparam int PHASES       = 10;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index   = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata   = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_restart = 1'b0;
   logic                       rsp_stall   = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_wind_sample;
   logic [COEF_W-1:0]          rsp_gust_gain;
   int                         fail_count;
   int                         words_waiting;
   int                         cycles = 0;
   bit                         calm = 1'b0;
   bit                         squeeze = 1'b0;

   wind_noise_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wind_sample (rsp_wind_sample),
      .rsp_gust_gain   (rsp_gust_gain)
   );

   wng_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wind_sample (rsp_wind_sample),
      .rsp_gust_gain   (rsp_gust_gain),
      .fail_count      (fail_count),
      .words_waiting   (words_waiting)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_coef();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return 32'h0000_FFFF;
      end
      return CSR_DATA_W'($urandom_range(0, 65535));
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_tick(input logic restart, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   // Wait until every word due has come out and the pipeline has drained.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic random_config();
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_SEED, $urandom);
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_NOISE_GAIN, pick_coef());
      end
      if ($urandom_range(0, 1) == 0) begin
         write_reg(CSR_LEAK, $urandom_range(60000, 65535));
      end else begin
         write_reg(CSR_LEAK, pick_coef());
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_SMOOTHING, pick_coef());
      end
      case ($urandom_range(0, 3))
         0: begin
            write_reg(CSR_LFO_INC, $urandom);
         end
         1: begin
            write_reg(CSR_LFO_INC, 32'h8000_0000);
         end
         default: begin
            write_reg(CSR_LFO_INC, $urandom_range(0, 4000000));
         end
      endcase
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_GUST_BASE, pick_coef());
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_GUST_DEPTH, pick_coef());
      end
      if ($urandom_range(0, 4) == 0) begin
         write_reg(CSR_SPARE, $urandom);
      end
      end_writes();
   endtask

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
   end

   // Output side: random stalls, and one long hold when asked for, so that
   // the block fills up and stalls its input.
   initial begin
      forever begin
         int gap;
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
         end else begin
            gap = gap_len();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, then a restart in the middle of a run.
      send_tick(1'b0, 0);
      send_tick(1'b0, 0);
      send_tick(1'b0, 1);
      send_tick(1'b1, 0);
      send_tick(1'b0, 2);
      settle();

      // Zero seed with every coefficient at full scale: the noise stays at its
      // most negative value, and the gust gain clips at the top and reaches zero
      // at the bottom as the phase steps through quarter turns.
      write_reg(CSR_SEED, '0);
      write_reg(CSR_NOISE_GAIN, 32'h0000_FFFF);
      write_reg(CSR_LEAK, 32'h0000_FFFF);
      write_reg(CSR_SMOOTHING, 32'h0000_FFFF);
      write_reg(CSR_LFO_INC, 32'h4000_0000);
      write_reg(CSR_GUST_BASE, 32'h0000_FFFF);
      write_reg(CSR_GUST_DEPTH, 32'h0000_FFFF);
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      end_writes();
      send_tick(1'b1, 0);
      repeat (5) send_tick(1'b0, 0);
      settle();

      // Zero base against full depth: the gain falls below zero and clips.
      write_reg(CSR_GUST_BASE, '0);
      write_reg(CSR_SEED, 32'hFFFF_FFFF);
      end_writes();
      send_tick(1'b1, 0);
      repeat (4) send_tick(1'b0, 0);
      settle();

      // All coefficients zero and a step beyond half a cycle.
      write_reg(CSR_SEED, 32'd1);
      write_reg(CSR_NOISE_GAIN, '0);
      write_reg(CSR_LEAK, '0);
      write_reg(CSR_SMOOTHING, '0);
      write_reg(CSR_LFO_INC, 32'hFFFF_FFFF);
      write_reg(CSR_GUST_DEPTH, '0);
      end_writes();
      send_tick(1'b1, 0);
      send_tick(1'b0, 0);
      send_tick(1'b0, 0);
      settle();

      write_reg(CSR_SEED, CFG_RESET.seed);
      write_reg(CSR_NOISE_GAIN, CSR_DATA_W'(CFG_RESET.noise_gain));
      write_reg(CSR_LEAK, CSR_DATA_W'(CFG_RESET.leak));
      write_reg(CSR_SMOOTHING, CSR_DATA_W'(CFG_RESET.smoothing_coef));
      write_reg(CSR_LFO_INC, 32'h8000_0000);
      write_reg(CSR_GUST_BASE, CSR_DATA_W'(CFG_RESET.gust_base));
      write_reg(CSR_GUST_DEPTH, CSR_DATA_W'(CFG_RESET.gust_depth));
      end_writes();
      send_tick(1'b1, 0);
      send_tick(1'b0, 0);
      send_tick(1'b0, 0);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase % 3 == 0);
         random_config();
         if (phase == 1) begin
            squeeze = 1'b1;
         end
         send_tick(1'b1, 0);
         for (int k = 1; k < RANDOM_TICKS / PHASES; k++) begin
            send_tick($urandom_range(0, 99) < 3, gap_len());
         end
         settle();
      end

      calm = 1'b1;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/wng_pkg.sv
rtl/wng_sine_rom.sv
rtl/wng_sequencer.sv
rtl/wng_datapath.sv
rtl/wind_noise_generator.sv
test/wng_checker.sv
test/tb_top.sv
